[design/assert_macros.svh]
// Assertion macros for the checker file of this project.
// ASSERT_CLK is disabled while reset is asserted; ASSERT_RST also holds during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[design/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Types, codes and widths shared by the bitmap block allocator files.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_BLOCKS_DEF    = 1024;
  localparam int ADDRESS_WIDTH_DEF = 32;

  // Width of the internal address arithmetic and of the divider dividend.
  localparam int CALC_W = 34;
  // Width of the divider divisor (alignment is the widest divisor).
  localparam int DIVS_W = 21;

  localparam int ADDR_W   = 32;
  localparam int BSIZE_W  = 17;
  localparam int BCOUNT_W = 11;
  localparam int NBYTES_W = 27;
  localparam int ALIGN_W  = 21;
  localparam int FREEB_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] MARK_FREE  = 2'd0;
  localparam logic [1:0] MARK_START = 2'd1;
  localparam logic [1:0] MARK_CONT  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BSIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BCOUNT = 2'd2;

  typedef struct packed {
    logic                command;
    logic [NBYTES_W-1:0] req_bytes;
    logic [ALIGN_W-1:0]  alignment;
    logic [ADDR_W-1:0]   free_address;
  } bba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  result_address;
    logic [1:0]         status;
    logic [FREEB_W-1:0] free_blocks;
  } bba_out_t;

endpackage

[design/bitmap_block_allocator.sv]
// After reset a clearing pass marks every block free; no item is taken meanwhile. A first-fit
// allocate runs a divide, a scan, the marking of the run and a count of the free blocks in use;
// a free runs a divide, a walk over the run and that count; an aligned allocate repeats its
// divides and its scan for each rejected candidate. The block takes one item at a time; the
// serial divider and the single map read port set how long each item takes.
// Reset is synchronous and active low; configuration returns to base 0, 64-byte blocks, 1024.
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a two-bit block map held in a synchronous RAM.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS    = NUM_BLOCKS_DEF,
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bba_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bba_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Index width of the map and width of a count that can hold NUM_BLOCKS itself.
  localparam int BW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int NW  = $clog2(NUM_BLOCKS + 1);
  localparam int MW  = NW + BSIZE_W;
  localparam int CW  = CALC_W;
  localparam int DVW = DIVS_W;
  localparam int DCW = $clog2(CALC_W + 1);
  // Returned addresses are cut to ADDRESS_WIDTH bits, and in any case to the port width.
  localparam int MASKW = (ADDRESS_WIDTH < ADDR_W) ? ADDRESS_WIDTH : ADDR_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << MASKW) - 64'd1);

  // Sequencer states.
  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_START   = 5'd2;
  localparam logic [4:0] S_FF_DIV  = 5'd3;
  localparam logic [4:0] S_FF_SCAN = 5'd4;
  localparam logic [4:0] S_MARK    = 5'd5;
  localparam logic [4:0] S_ADDR    = 5'd6;
  localparam logic [4:0] S_AL_INIT = 5'd7;
  localparam logic [4:0] S_AL_CHK  = 5'd8;
  localparam logic [4:0] S_AL_DB   = 5'd9;
  localparam logic [4:0] S_AL_DL   = 5'd10;
  localparam logic [4:0] S_AL_SCAN = 5'd11;
  localparam logic [4:0] S_AL_TGT  = 5'd12;
  localparam logic [4:0] S_AL_TGT2 = 5'd13;
  localparam logic [4:0] S_AL_STEP = 5'd14;
  localparam logic [4:0] S_FR_DIV  = 5'd15;
  localparam logic [4:0] S_FR_WALK = 5'd16;
  localparam logic [4:0] S_COUNT   = 5'd17;
  localparam logic [4:0] S_FIN     = 5'd18;

  // Configuration registers.
  logic [ADDR_W-1:0]   cfg_base_r;
  logic [BSIZE_W-1:0]  cfg_bsize_r;
  logic [BCOUNT_W-1:0] cfg_bcount_r;

  // Sequencer registers.
  logic [4:0]     state_r, state_nxt;
  bba_in_t        in_r, in_nxt;
  logic [NW-1:0]  ptr_r, ptr_nxt;
  logic           rv_r, rv_nxt;
  logic [NW-1:0]  ridx_r, ridx_nxt;
  logic [NW-1:0]  run_r, run_nxt;
  logic [NW-1:0]  units_r, units_nxt;
  logic [NW-1:0]  first_r, first_nxt;
  logic [NW-1:0]  last_r, last_nxt;
  logic           busy_r, busy_nxt;
  logic [NW-1:0]  lastb_r, lastb_nxt;
  logic [NW-1:0]  mul_a_r, mul_a_nxt;
  logic [MW-1:0]  mul_r, mul_nxt;
  logic [CW-1:0]  cand_r, cand_nxt;
  logic [CW-1:0]  end_r, end_nxt;
  logic [CW-1:0]  tgt_r, tgt_nxt;
  logic [CW-1:0]  res_r, res_nxt;
  logic [1:0]     st_r, st_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  bba_out_t       out_data_r, out_data_nxt;

  // Shared restoring divider, one quotient bit a cycle.
  logic           div_start;
  logic [CW-1:0]  div_a;
  logic [DVW-1:0] div_b;
  logic           div_busy_r, div_busy_nxt;
  logic [DCW-1:0] div_cnt_r, div_cnt_nxt;
  logic [DVW:0]   div_rem_r, div_rem_nxt;
  logic [CW-1:0]  div_quo_r, div_quo_nxt;
  logic [DVW-1:0] div_dvs_r, div_dvs_nxt;
  logic [DVW:0]   dv_sh, dv_diff;
  logic           dv_ge;

  // Map RAM ports.
  logic          map_we;
  logic [BW-1:0] map_waddr;
  logic [1:0]    map_wdata;
  logic [BW-1:0] map_raddr;
  logic [1:0]    map_rdata;

  // Effective configuration and helpers.
  logic [BSIZE_W-1:0] bs_eff;
  logic [NW-1:0]      n_eff;
  logic [CW-1:0]      n_ext, base_ext, bs_ext, align_ext, pad;
  logic [DVW-1:0]     div_r;
  logic               rd_free;
  logic               issue, leave, to_count;
  logic               busy_c;
  logic [NW-1:0]      lastb_c;
  logic [NW-1:0]      run_start;
  logic [CW-1:0]      tgt_c;

  bba_ram #(
    .WIDTH (2),
    .DEPTH (NUM_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // A block size of zero acts as one; the block count is held between one and NUM_BLOCKS.
  always_comb begin
    bs_eff = (cfg_bsize_r == '0) ? BSIZE_W'(1) : cfg_bsize_r;
    if (cfg_bcount_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(cfg_bcount_r) > NUM_BLOCKS) begin
      n_eff = NW'(NUM_BLOCKS);
    end else begin
      n_eff = NW'(cfg_bcount_r);
    end
  end

  assign n_ext     = CW'(n_eff);
  assign base_ext  = CW'(cfg_base_r);
  assign bs_ext    = CW'(bs_eff);
  assign align_ext = CW'(in_r.alignment);
  assign div_r     = div_rem_r[DVW-1:0];
  // Distance from a value to the next multiple of the alignment, given its remainder.
  assign pad       = (div_r == '0) ? '0 : (align_ext - CW'(div_r));
  assign rd_free   = (map_rdata == MARK_FREE);
  assign mul_nxt   = MW'(mul_a_r) * MW'(bs_eff);
  assign tgt_c     = base_ext + CW'(mul_r);

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r   <= '0;
      cfg_bsize_r  <= BSIZE_W'(64);
      cfg_bcount_r <= BCOUNT_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE:   cfg_base_r   <= cfg_wdata[ADDR_W-1:0];
        CFG_BSIZE:  cfg_bsize_r  <= cfg_wdata[BSIZE_W-1:0];
        CFG_BCOUNT: cfg_bcount_r <= cfg_wdata[BCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider step: shift in the next dividend bit and subtract where the divisor fits.
  always_comb begin
    dv_sh   = {div_rem_r[DVW-1:0], div_quo_r[CW-1]};
    dv_ge   = (dv_sh >= {1'b0, div_dvs_r});
    dv_diff = dv_sh - {1'b0, div_dvs_r};
    div_busy_nxt = div_busy_r;
    div_cnt_nxt  = div_cnt_r;
    div_rem_nxt  = div_rem_r;
    div_quo_nxt  = div_quo_r;
    div_dvs_nxt  = div_dvs_r;
    if (div_start) begin
      div_busy_nxt = 1'b1;
      div_cnt_nxt  = DCW'(CW);
      div_rem_nxt  = '0;
      div_quo_nxt  = div_a;
      div_dvs_nxt  = div_b;
    end else if (div_busy_r) begin
      div_rem_nxt = dv_ge ? dv_diff : dv_sh;
      div_quo_nxt = {div_quo_r[CW-2:0], dv_ge};
      div_cnt_nxt = div_cnt_r - DCW'(1);
      if (div_cnt_r == DCW'(1)) begin
        div_busy_nxt = 1'b0;
      end
    end
  end

  // Main sequencer. Every map access is ordered by the sequencer: reads of a scan never meet a
  // write to the same entry, and the free walk writes an entry after its read has returned.
  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    ptr_nxt       = ptr_r;
    run_nxt       = run_r;
    units_nxt     = units_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    busy_nxt      = busy_r;
    lastb_nxt     = lastb_r;
    mul_a_nxt     = mul_a_r;
    cand_nxt      = cand_r;
    end_nxt       = end_r;
    tgt_nxt       = tgt_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_start     = 1'b0;
    div_a         = '0;
    div_b         = '0;
    map_we        = 1'b0;
    map_waddr     = ptr_r[BW-1:0];
    map_wdata     = MARK_FREE;
    map_raddr     = ptr_r[BW-1:0];
    issue         = 1'b0;
    leave         = 1'b0;
    to_count      = 1'b0;
    busy_c        = busy_r || !rd_free;
    lastb_c       = rd_free ? lastb_r : ridx_r;
    run_start     = ridx_r + NW'(1) - units_r;

    unique case (state_r)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_wdata = MARK_FREE;
        ptr_nxt   = ptr_r + NW'(1);
        if (ptr_r == NW'(NUM_BLOCKS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_START;
        end
      end

      S_START: begin
        res_nxt   = '0;
        mul_a_nxt = n_eff;
        if (in_r.command == CMD_FREE) begin
          if (in_r.free_address < cfg_base_r) begin
            st_nxt   = ST_BADFREE;
            to_count = 1'b1;
          end else begin
            div_start = 1'b1;
            div_a     = CW'(in_r.free_address) - base_ext;
            div_b     = DVW'(bs_eff);
            state_nxt = S_FR_DIV;
          end
        end else if (in_r.req_bytes == '0) begin
          st_nxt   = ST_ZERO;
          to_count = 1'b1;
        end else if (in_r.alignment == '0) begin
          div_start = 1'b1;
          div_a     = CW'(in_r.req_bytes) + bs_ext - CW'(1);
          div_b     = DVW'(bs_eff);
          state_nxt = S_FF_DIV;
        end else begin
          div_start = 1'b1;
          div_a     = base_ext;
          div_b     = in_r.alignment;
          state_nxt = S_AL_INIT;
        end
      end

      // First fit: the run length in blocks is the rounded-up quotient.
      S_FF_DIV: begin
        if (!div_busy_r) begin
          if (div_quo_r > n_ext) begin
            st_nxt   = ST_NOSPACE;
            to_count = 1'b1;
          end else begin
            units_nxt = div_quo_r[NW-1:0];
            ptr_nxt   = '0;
            run_nxt   = '0;
            state_nxt = S_FF_SCAN;
          end
        end
      end

      S_FF_SCAN: begin
        issue = (ptr_r < n_eff);
        if (issue) begin
          ptr_nxt = ptr_r + NW'(1);
        end
        if (rv_r) begin
          if (rd_free && (run_r + NW'(1) == units_r)) begin
            first_nxt = run_start;
            last_nxt  = ridx_r;
            ptr_nxt   = run_start;
            mul_a_nxt = run_start;
            leave     = 1'b1;
            state_nxt = S_MARK;
          end else begin
            run_nxt = rd_free ? (run_r + NW'(1)) : '0;
            if (ridx_r == n_eff - NW'(1)) begin
              st_nxt   = ST_NOSPACE;
              to_count = 1'b1;
            end
          end
        end
      end

      // Writes the run: a start mark on its first block, continuation marks after it.
      S_MARK: begin
        map_we    = 1'b1;
        map_wdata = (ptr_r == first_r) ? MARK_START : MARK_CONT;
        if (ptr_r == last_r) begin
          state_nxt = S_ADDR;
        end else begin
          ptr_nxt = ptr_r + NW'(1);
        end
      end

      S_ADDR: begin
        res_nxt  = (in_r.alignment == '0) ? (base_ext + CW'(mul_r)) : cand_r;
        st_nxt   = ST_OK;
        to_count = 1'b1;
      end

      // Aligned fit: first candidate is the base rounded up to the alignment.
      S_AL_INIT: begin
        if (!div_busy_r) begin
          cand_nxt  = base_ext + pad;
          end_nxt   = base_ext + CW'(mul_r);
          state_nxt = S_AL_CHK;
        end
      end

      S_AL_CHK: begin
        if (cand_r >= end_r) begin
          st_nxt   = ST_NOSPACE;
          to_count = 1'b1;
        end else begin
          div_start = 1'b1;
          div_a     = cand_r - base_ext;
          div_b     = DVW'(bs_eff);
          state_nxt = S_AL_DB;
        end
      end

      S_AL_DB: begin
        if (!div_busy_r) begin
          first_nxt = div_quo_r[NW-1:0];
          div_start = 1'b1;
          div_a     = cand_r + CW'(in_r.req_bytes) - CW'(1) - base_ext;
          div_b     = DVW'(bs_eff);
          state_nxt = S_AL_DL;
        end
      end

      // A candidate whose last block lies past the map end stops the search.
      S_AL_DL: begin
        if (!div_busy_r) begin
          if (div_quo_r >= n_ext) begin
            st_nxt   = ST_NOSPACE;
            to_count = 1'b1;
          end else begin
            last_nxt  = div_quo_r[NW-1:0];
            ptr_nxt   = first_r;
            busy_nxt  = 1'b0;
            state_nxt = S_AL_SCAN;
          end
        end
      end

      S_AL_SCAN: begin
        issue = (ptr_r <= last_r);
        if (issue) begin
          ptr_nxt = ptr_r + NW'(1);
        end
        if (rv_r) begin
          busy_nxt  = busy_c;
          lastb_nxt = lastb_c;
          if (ridx_r == last_r) begin
            leave = 1'b1;
            if (!busy_c) begin
              ptr_nxt   = first_r;
              state_nxt = S_MARK;
            end else begin
              mul_a_nxt = lastb_c + NW'(1);
              state_nxt = S_AL_TGT;
            end
          end
        end
      end

      // Waits for the product that gives the end of the last busy block.
      S_AL_TGT: begin
        state_nxt = S_AL_TGT2;
      end

      // Every candidate at or before the last busy block fails: skip to the first aligned
      // address at or above the end of that block.
      S_AL_TGT2: begin
        tgt_nxt   = tgt_c;
        div_start = 1'b1;
        div_a     = tgt_c - cand_r;
        div_b     = in_r.alignment;
        state_nxt = S_AL_STEP;
      end

      S_AL_STEP: begin
        if (!div_busy_r) begin
          cand_nxt  = tgt_r + pad;
          state_nxt = S_AL_CHK;
        end
      end

      S_FR_DIV: begin
        if (!div_busy_r) begin
          if (div_quo_r >= n_ext) begin
            st_nxt   = ST_BADFREE;
            to_count = 1'b1;
          end else begin
            ptr_nxt   = div_quo_r[NW-1:0];
            first_nxt = div_quo_r[NW-1:0];
            state_nxt = S_FR_WALK;
          end
        end
      end

      // The free walk clears the start mark and the continuation marks that follow it.
      S_FR_WALK: begin
        issue = (ptr_r < n_eff);
        if (issue) begin
          ptr_nxt = ptr_r + NW'(1);
        end
        if (rv_r) begin
          map_waddr = ridx_r[BW-1:0];
          map_wdata = MARK_FREE;
          if (ridx_r == first_r) begin
            if (map_rdata != MARK_START) begin
              st_nxt   = ST_BADFREE;
              to_count = 1'b1;
            end else begin
              map_we = 1'b1;
              if (ridx_r == n_eff - NW'(1)) begin
                st_nxt   = ST_OK;
                to_count = 1'b1;
              end
            end
          end else if (map_rdata == MARK_CONT) begin
            map_we = 1'b1;
            if (ridx_r == n_eff - NW'(1)) begin
              st_nxt   = ST_OK;
              to_count = 1'b1;
            end
          end else begin
            st_nxt   = ST_OK;
            to_count = 1'b1;
          end
        end
      end

      // Counts the free marks among the blocks in use.
      S_COUNT: begin
        issue = (ptr_r < n_eff);
        if (issue) begin
          ptr_nxt = ptr_r + NW'(1);
        end
        if (rv_r) begin
          cnt_nxt = cnt_r + NW'(rd_free);
          if (ridx_r == n_eff - NW'(1)) begin
            leave     = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.result_address = res_r[ADDR_W-1:0] & ADDR_MASK;
          out_data_nxt.status         = st_r;
          out_data_nxt.free_blocks    = FREEB_W'(cnt_r);
          out_valid_nxt               = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (to_count) begin
      if (st_nxt != ST_OK) begin
        res_nxt = '0;
      end
      ptr_nxt   = '0;
      cnt_nxt   = '0;
      leave     = 1'b1;
      state_nxt = S_COUNT;
    end
    rv_nxt   = issue && !leave;
    ridx_nxt = ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      div_busy_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      div_busy_r  <= div_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    ridx_r     <= ridx_nxt;
    run_r      <= run_nxt;
    units_r    <= units_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    busy_r     <= busy_nxt;
    lastb_r    <= lastb_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_r      <= mul_nxt;
    cand_r     <= cand_nxt;
    end_r      <= end_nxt;
    tgt_r      <= tgt_nxt;
    res_r      <= res_nxt;
    st_r       <= st_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    div_cnt_r  <= div_cnt_nxt;
    div_rem_r  <= div_rem_nxt;
    div_quo_r  <= div_quo_nxt;
    div_dvs_r  <= div_dvs_nxt;
  end

  // The block takes one item at a time; a finished result may still wait in the output register.
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/bba_checker.sv]
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_checker
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input bba_out_t out_data
);

  // Transactions taken in whose results have not yet been taken out.
  logic [1:0] pend_r, pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `ASSERT_CLK(a_no_orphan, clk, rst_n, out_valid |-> pend_r != 2'd0, "result without a pending transaction")
  `ASSERT_CLK(a_err_addr, clk, rst_n, out_valid && out_data.status != ST_OK |-> out_data.result_address == '0, "error result carries an address")
  `ASSERT_CLK(a_free_bound, clk, rst_n, out_valid |-> 32'(out_data.free_blocks) <= NUM_BLOCKS, "free count above map size")
  `ASSERT_RST(a_rst_out, clk, !rst_n |=> !out_valid, "result shown after reset")

endmodule

bind bitmap_block_allocator bba_checker #(.NUM_BLOCKS(NUM_BLOCKS)) u_bba_checker (.*);
